// File: src/hvt_pkg.sv
package hvt_pkg;

  localparam int MAT_W     = 32;  // matrix entry width
  localparam int FIELD_W   = 32;  // coordinate port width
  localparam int CFG_W     = 64;  // configuration register width
  localparam int CFG_IDX_W = 4;   // configuration index port width
  localparam int NUM_REGS  = 8;
  localparam int REG_IDX_W = $clog2(NUM_REGS);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROW0_C01 = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_ROW0_C23 = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_ROW1_C01 = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_ROW1_C23 = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_ROW2_C01 = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_ROW2_C23 = CFG_IDX_W'(5);
  localparam logic [CFG_IDX_W-1:0] REG_ROW3_C01 = CFG_IDX_W'(6);
  localparam logic [CFG_IDX_W-1:0] REG_ROW3_C23 = CFG_IDX_W'(7);

  // mat[row][col]
  typedef logic [3:0][3:0][MAT_W-1:0] mat_t;

endpackage

// File: src/hvt_cfg.sv
module hvt_cfg import hvt_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]     cfg_wdata,
  output mat_t                 mat
);

  localparam logic [CFG_W-1:0] ONE_LO = CFG_W'(1) << FRAC_BITS;
  localparam logic [CFG_W-1:0] ONE_HI = ONE_LO << MAT_W;

  // identity matrix, highest register first
  localparam logic [NUM_REGS-1:0][CFG_W-1:0] REGS_RST = {
    ONE_HI, {CFG_W{1'b0}}, ONE_LO, {CFG_W{1'b0}},
    {CFG_W{1'b0}}, ONE_HI, {CFG_W{1'b0}}, ONE_LO
  };

  logic [NUM_REGS-1:0][CFG_W-1:0] regs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r <= REGS_RST;
    end else if (cfg_we && (cfg_addr <= REG_ROW3_C23)) begin
      regs_r[cfg_addr[REG_IDX_W-1:0]] <= cfg_wdata;
    end
  end

  // even column in the low half, odd column in the high half
  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        mat[r][c] = regs_r[r*2 + c/2][(c%2)*MAT_W +: MAT_W];
      end
    end
  end

endmodule

// File: src/hvt_dot.sv
module hvt_dot import hvt_pkg::*; #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16,
  parameter int ACC_W       = 50
) (
  input  logic                          clk,
  input  logic                          en,
  input  mat_t                          mat,
  input  logic signed [COORD_WIDTH-1:0] vx,
  input  logic signed [COORD_WIDTH-1:0] vy,
  input  logic signed [COORD_WIDTH-1:0] vz,
  output logic signed [ACC_W-1:0]       acc [4]
);

  localparam int PROD_W = MAT_W + COORD_WIDTH;

  logic signed [COORD_WIDTH-1:0] v [3];
  logic signed [PROD_W-1:0]      prod_r [4][3];
  logic signed [MAT_W-1:0]       wcol_r [4];
  logic signed [ACC_W-1:0]       acc_r  [4];
  logic signed [ACC_W-1:0]       acc_nxt [4];

  assign v[0] = vx;
  assign v[1] = vy;
  assign v[2] = vz;

  // stage 1: products; the w column meets 1.0, so its term is the entry itself
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 3; j++) begin
          prod_r[i][j] <= $signed(mat[i][j]) * v[j];
        end
        wcol_r[i] <= $signed(mat[i][3]);
      end
    end
  end

  // stage 2: floor shift and sum
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      acc_nxt[i] = ACC_W'(prod_r[i][0] >>> FRAC_BITS)
                 + ACC_W'(prod_r[i][1] >>> FRAC_BITS)
                 + ACC_W'(prod_r[i][2] >>> FRAC_BITS)
                 + ACC_W'(wcol_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) acc_r[i] <= acc_nxt[i];
    end
  end

  assign acc = acc_r;

endmodule

// File: src/hvt_div_lane.sv
module hvt_div_lane import hvt_pkg::*; #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16,
  parameter int ACC_W       = 50
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [ACC_W-1:0]       num,
  input  logic signed [ACC_W-1:0]       den,
  output logic signed [COORD_WIDTH-1:0] quo,
  output logic                          sat,
  output logic                          den_zero
);

  localparam int R_W = ACC_W + FRAC_BITS + COORD_WIDTH;
  localparam logic [COORD_WIDTH-1:0] LIM_NEG = COORD_WIDTH'(1) << (COORD_WIDTH - 1);
  localparam logic [COORD_WIDTH-1:0] LIM_POS = LIM_NEG - COORD_WIDTH'(1);

  logic [ACC_W-1:0] a_r, b_r;
  logic             neg_a_r, dz_a_r;

  logic [R_W-1:0]         rem_r [COORD_WIDTH+1];
  logic [R_W-1:0]         dvs_r [COORD_WIDTH+1];
  logic [COORD_WIDTH-1:0] q_r   [COORD_WIDTH+1];
  logic                   ovf_r [COORD_WIDTH+1];
  logic                   neg_r [COORD_WIDTH+1];
  logic                   dz_r  [COORD_WIDTH+1];

  // magnitudes and sign of the quotient
  always_ff @(posedge clk) begin
    if (en) begin
      a_r     <= num[ACC_W-1] ? ACC_W'(-num) : ACC_W'(num);
      b_r     <= den[ACC_W-1] ? ACC_W'(-den) : ACC_W'(den);
      neg_a_r <= num[ACC_W-1] ^ den[ACC_W-1];
      dz_a_r  <= (den == '0);
    end
  end

  // scaled dividend, and overflow when the quotient needs more than COORD_WIDTH bits
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= R_W'(a_r) << FRAC_BITS;
      dvs_r[0] <= R_W'(b_r);
      ovf_r[0] <= (R_W'(a_r) << FRAC_BITS) >= (R_W'(b_r) << COORD_WIDTH);
      neg_r[0] <= neg_a_r;
      dz_r[0]  <= dz_a_r;
      q_r[0]   <= '0;
    end
  end

  // one quotient bit per stage, MSB first
  for (genvar s = 0; s < COORD_WIDTH; s++) begin : g_bit
    localparam int K = COORD_WIDTH - 1 - s;
    logic [R_W-1:0] trial;
    logic           take;

    assign trial = dvs_r[s] << K;
    assign take  = rem_r[s] >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s+1] <= take ? rem_r[s] - trial : rem_r[s];
        q_r[s+1]   <= q_r[s] | (take ? (COORD_WIDTH'(1) << K) : '0);
        dvs_r[s+1] <= dvs_r[s];
        ovf_r[s+1] <= ovf_r[s];
        neg_r[s+1] <= neg_r[s];
        dz_r[s+1]  <= dz_r[s];
      end
    end
  end

  logic [COORD_WIDTH-1:0] qv;
  assign qv = q_r[COORD_WIDTH];

  always_comb begin
    quo      = '0;
    sat      = 1'b0;
    den_zero = dz_r[COORD_WIDTH];
    if (dz_r[COORD_WIDTH]) begin
      quo = '0;
    end else if (ovf_r[COORD_WIDTH]) begin
      sat = 1'b1;
      quo = neg_r[COORD_WIDTH] ? $signed(LIM_NEG) : $signed(LIM_POS);
    end else if (neg_r[COORD_WIDTH]) begin
      if (qv > LIM_NEG) begin
        sat = 1'b1;
        quo = $signed(LIM_NEG);
      end else begin
        quo = $signed(-qv);
      end
    end else begin
      if (qv > LIM_POS) begin
        sat = 1'b1;
        quo = $signed(LIM_POS);
      end else begin
        quo = $signed(qv);
      end
    end
  end

endmodule

// File: src/homogeneous_vertex_transform_core.sv
// Channel  | Handshake              | Payload
// input    | in_valid / in_ready    | in_x, in_y, in_z
// result   | out_valid / out_ready  | out_x, out_y, out_z, out_w_zero, out_saturated
// config   | cfg_we                 | cfg_addr, cfg_wdata
//
// One vertex per cycle unless a stalled result holds the pipeline.
// Depth is set by the divider: one quotient bit per stage, three lanes in parallel.
// Synchronous active-low reset clears the valid bits and loads the identity matrix.
// A stalled result freezes the whole pipeline; in_ready drops only while it waits.
module homogeneous_vertex_transform_core import hvt_pkg::*; #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [FIELD_W-1:0] in_x,
  input  logic signed [FIELD_W-1:0] in_y,
  input  logic signed [FIELD_W-1:0] in_z,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [FIELD_W-1:0] out_x,
  output logic signed [FIELD_W-1:0] out_y,
  output logic signed [FIELD_W-1:0] out_z,
  output logic                     out_w_zero,
  output logic                     out_saturated,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_addr,
  input  logic [CFG_W-1:0]         cfg_wdata
);

  localparam int SH_W  = MAT_W + COORD_WIDTH - FRAC_BITS;
  localparam int ACC_W = ((SH_W > MAT_W) ? SH_W : MAT_W) + 2;
  localparam int NSTG  = COORD_WIDTH + 4;  // registers ahead of the output register

  mat_t                          mat;
  logic                          adv;
  logic [NSTG-1:0]               vld_r;
  logic signed [ACC_W-1:0]       acc [4];
  logic signed [COORD_WIDTH-1:0] quo [3];
  logic [2:0]                    lsat, ldz;

  logic                     out_valid_r, out_w_zero_r, out_sat_r;
  logic signed [FIELD_W-1:0] out_x_r, out_y_r, out_z_r;

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  hvt_cfg #(.FRAC_BITS(FRAC_BITS)) u_cfg (
    .clk, .rst_n, .cfg_we, .cfg_addr, .cfg_wdata, .mat
  );

  hvt_dot #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS), .ACC_W(ACC_W)) u_dot (
    .clk, .en(adv), .mat,
    .vx($signed(in_x[COORD_WIDTH-1:0])),
    .vy($signed(in_y[COORD_WIDTH-1:0])),
    .vz($signed(in_z[COORD_WIDTH-1:0])),
    .acc
  );

  for (genvar l = 0; l < 3; l++) begin : g_lane
    hvt_div_lane #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS), .ACC_W(ACC_W)) u_div (
      .clk, .en(adv), .num(acc[l]), .den(acc[3]),
      .quo(quo[l]), .sat(lsat[l]), .den_zero(ldz[l])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r       <= {vld_r[NSTG-2:0], in_valid};
      out_valid_r <= vld_r[NSTG-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_x_r      <= FIELD_W'(quo[0]);
      out_y_r      <= FIELD_W'(quo[1]);
      out_z_r      <= FIELD_W'(quo[2]);
      out_w_zero_r <= ldz[0];
      out_sat_r    <= |lsat;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_x         = out_x_r;
  assign out_y         = out_y_r;
  assign out_z         = out_z_r;
  assign out_w_zero    = out_w_zero_r;
  assign out_saturated = out_sat_r;

  a_wz_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_w_zero_r) |->
      (out_x_r == '0 && out_y_r == '0 && out_z_r == '0 && !out_sat_r))
    else $error("zero w result carries data");

  // only meaningful once a request has reached the last divider stage
  a_lanes_agree: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[NSTG-1] |-> ((ldz[0] == ldz[1]) && (ldz[1] == ldz[2])))
    else $error("divider lanes disagree on zero w");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && vld_r[NSTG-1]) |=> out_valid_r)
    else $error("request lost at output register");

endmodule

// File: test/tb_homogeneous_vertex_transform_core.sv
`timescale 1ns / 1ps

module tb_homogeneous_vertex_transform_core import hvt_pkg::*; ();

  typedef struct {
    logic signed [FIELD_W-1:0] x;
    logic signed [FIELD_W-1:0] y;
    logic signed [FIELD_W-1:0] z;
  } vertex_t;

  typedef struct {
    logic signed [FIELD_W-1:0] x;
    logic signed [FIELD_W-1:0] y;
    logic signed [FIELD_W-1:0] z;
    logic                      w_zero;
    logic                      saturated;
  } projected_t;

  localparam int FRAC       = 16;
  localparam int PIPE_DEPTH = 32 + 5;
  localparam int CYCLE_CAP  = 400000;
  localparam logic [MAT_W-1:0] ONE = 32'h0001_0000;

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready;
  logic signed [FIELD_W-1:0] in_x, in_y, in_z, out_x, out_y, out_z;
  logic out_w_zero, out_saturated;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_addr;
  logic [CFG_W-1:0] cfg_wdata;

  logic [CFG_W-1:0] matrix_regs [NUM_REGS];
  vertex_t    vertex_q[$];
  projected_t projected_q[$];
  int send_idle, recv_idle;
  int errors;
  int cycles;

  homogeneous_vertex_transform_core dut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [FIELD_W-1:0] divide_coord(logic signed [63:0] num,
                                                      logic signed [63:0] den,
                                                      ref logic sat);
    logic        neg;
    logic [63:0] a, b;
    logic [127:0] q;
    neg = num[63] ^ den[63];
    a = num[63] ? -num : num;
    b = den[63] ? -den : den;
    q = ({64'd0, a} << FRAC) / {64'd0, b};
    if (neg) begin
      if (q > 128'h8000_0000) begin
        q = 128'h8000_0000;
        sat = 1'b1;
      end
      return -q[31:0];
    end
    if (q > 128'h7FFF_FFFF) begin
      q = 128'h7FFF_FFFF;
      sat = 1'b1;
    end
    return q[31:0];
  endfunction

  function automatic projected_t project_vertex(vertex_t vtx);
    logic signed [63:0] comp [4];
    logic signed [63:0] acc [4];
    logic signed [MAT_W-1:0] e32;
    logic signed [63:0] e;
    logic sat;
    projected_t r;
    comp[0] = vtx.x;
    comp[1] = vtx.y;
    comp[2] = vtx.z;
    comp[3] = 64'sd65536;
    for (int i = 0; i < 4; i++) begin
      acc[i] = 0;
      for (int j = 0; j < 4; j++) begin
        e32 = matrix_regs[i*2 + j/2][(j%2)*32 +: 32];
        e = e32;
        acc[i] += (e * comp[j]) >>> FRAC;
      end
    end
    sat = 1'b0;
    if (acc[3] == 0) begin
      r.x = 0; r.y = 0; r.z = 0;
      r.w_zero = 1'b1;
      r.saturated = 1'b0;
      return r;
    end
    r.x = divide_coord(acc[0], acc[3], sat);
    r.y = divide_coord(acc[1], acc[3], sat);
    r.z = divide_coord(acc[2], acc[3], sat);
    r.w_zero = 1'b0;
    r.saturated = sat;
    return r;
  endfunction

  function automatic logic [MAT_W-1:0] rand_entry();
    case ($urandom_range(5))
      0: return $urandom;
      1: return MAT_W'($signed($urandom_range(524288)) - 262144);
      2: return $urandom_range(1) ? ONE : -ONE;
      3: return 0;
      4: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return MAT_W'(ONE + $signed($urandom_range(8192)) - 4096);
    endcase
  endfunction

  function automatic logic [FIELD_W-1:0] rand_coord();
    case ($urandom_range(3))
      0: return $urandom;
      1: return FIELD_W'($signed($urandom_range(2097152)) - 1048576);
      2: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return FIELD_W'($signed($urandom_range(64)) - 32);
    endcase
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    if (idx < NUM_REGS) matrix_regs[idx] = val;
  endtask

  // m[row][col], written through the eight row-pair registers
  task automatic load_matrix(logic [3:0][3:0][MAT_W-1:0] m);
    write_reg(REG_ROW0_C01, {m[0][1], m[0][0]});
    write_reg(REG_ROW0_C23, {m[0][3], m[0][2]});
    write_reg(REG_ROW1_C01, {m[1][1], m[1][0]});
    write_reg(REG_ROW1_C23, {m[1][3], m[1][2]});
    write_reg(REG_ROW2_C01, {m[2][1], m[2][0]});
    write_reg(REG_ROW2_C23, {m[2][3], m[2][2]});
    write_reg(REG_ROW3_C01, {m[3][1], m[3][0]});
    write_reg(REG_ROW3_C23, {m[3][3], m[3][2]});
    // junk to an unmapped index must leave the matrix alone
    write_reg(CFG_IDX_W'(NUM_REGS + $urandom_range(NUM_REGS - 1)), {$urandom, $urandom});
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic push_vertex(logic [FIELD_W-1:0] x, logic [FIELD_W-1:0] y,
                             logic [FIELD_W-1:0] z);
    vertex_t v;
    v.x = x; v.y = y; v.z = z;
    vertex_q.insert(vertex_q.size(), v);
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        vertex_t v;
        v.x = in_x; v.y = in_y; v.z = in_z;
        projected_q.insert(projected_q.size(), project_vertex(v));
      end
      if (!in_valid || in_ready) begin
        if (vertex_q.size() > 0 && $urandom_range(99) >= send_idle) begin
          vertex_t v;
          v = vertex_q.pop_front();
          in_valid <= 1'b1;
          in_x <= v.x;
          in_y <= v.y;
          in_z <= v.z;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle);
      if (out_valid && out_ready) begin
        if (projected_q.size() == 0) begin
          $error("result with no request outstanding");
          errors++;
        end else begin
          projected_t e;
          e = projected_q.pop_front();
          if (out_x !== e.x) begin
            $error("out_x expected %h got %h", e.x, out_x); errors++;
          end
          if (out_y !== e.y) begin
            $error("out_y expected %h got %h", e.y, out_y); errors++;
          end
          if (out_z !== e.z) begin
            $error("out_z expected %h got %h", e.z, out_z); errors++;
          end
          if (out_w_zero !== e.w_zero) begin
            $error("out_w_zero expected %b got %b", e.w_zero, out_w_zero); errors++;
          end
          if (out_saturated !== e.saturated) begin
            $error("out_saturated expected %b got %b", e.saturated, out_saturated);
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("homogeneous_vertex_transform_core: mismatch");
      $finish;
    end
  end

  initial begin
    logic [3:0][3:0][MAT_W-1:0] m;
    logic [FIELD_W-1:0] edges [6];
    errors = 0;
    cycles = 0;
    send_idle = 33;
    recv_idle = 84;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_x = 0; in_y = 0; in_z = 0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = 0;
    cfg_wdata = 0;
    for (int i = 0; i < NUM_REGS; i++) matrix_regs[i] = 0;
    matrix_regs[0] = CFG_W'(ONE);
    matrix_regs[2] = CFG_W'(ONE) << 32;
    matrix_regs[5] = CFG_W'(ONE);
    matrix_regs[7] = CFG_W'(ONE) << 32;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // reset matrix first, untouched
    edges = '{32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h1, ONE};
    for (int i = 0; i < 6; i++) push_vertex(edges[i], edges[5 - i], edges[(i + 2) % 6]);
    push_vertex(-ONE, ONE, 32'h8000_0000);

    for (int phase = 0; phase < 10; phase++) begin
      while (vertex_q.size() > 0 || in_valid || projected_q.size() > 0) @(posedge clk);
      repeat (PIPE_DEPTH) @(posedge clk);
      if (phase < 4) begin
        send_idle = 33; recv_idle = 84;
      end else if (phase < 7) begin
        send_idle = 84; recv_idle = 33;
      end else begin
        send_idle = 0; recv_idle = 0;
      end
      for (int r = 0; r < 4; r++)
        for (int c = 0; c < 4; c++)
          m[r][c] = rand_entry();
      case (phase)
        0: begin
          m = '0;
          for (int r = 0; r < 4; r++) m[r][r] = ONE;
        end
        1: m[3] = '0;  // w always zero
        2: for (int r = 0; r < 4; r++) m[r] = {4{32'h7FFF_FFFF}};
        3: for (int r = 0; r < 4; r++) m[r] = {4{32'h8000_0000}};
        4: begin  // w pinned at one: plain affine, large entries overflow
          m[3] = '0;
          m[3][3] = ONE;
        end
        default: ;
      endcase
      load_matrix(m);
      if (phase == 0) begin
        for (int i = 0; i < 6; i++) push_vertex(edges[i], edges[i], edges[5 - i]);
        push_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
        push_vertex(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      end
      for (int i = 0; i < 62; i++) push_vertex(rand_coord(), rand_coord(), rand_coord());
    end

    while (vertex_q.size() > 0 || in_valid || projected_q.size() > 0) @(posedge clk);
    repeat (PIPE_DEPTH) @(posedge clk);
    if (errors == 0) begin
      $display("homogeneous_vertex_transform_core: match");
    end else begin
      $display("homogeneous_vertex_transform_core: mismatch");
    end
    $finish;
  end

endmodule
